FILE: hw/rtl/bti_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the bilinear table interpolator.
// No dependencies.
package bti_pkg;

	typedef enum logic [1:0] {
		OP_WR_TB  = 2'd0,
		OP_WR_D   = 2'd1,
		OP_WR_TBL = 2'd2,
		OP_EVAL   = 2'd3
	} op_t;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_SRCH = 7'b0000010,
		ST_TRD  = 7'b0000100,
		ST_DIVI = 7'b0001000,
		ST_DIV  = 7'b0010000,
		ST_LRP  = 7'b0100000,
		ST_OUT  = 7'b1000000
	} state_t;

	localparam int unsigned DATA_W = 32;
	localparam int unsigned QBITS  = 31;       // quotient bits computed per weight
	localparam logic [30:0] W_LIMIT = 31'h4000_0000;

endpackage

FILE: hw/rtl/bilinear_table_interpolator_core.sv
`timescale 1ns / 1ps
// Bilinear interpolation over a non-uniform 2D grid held in on-chip memories.
// Depends on bti_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready) carries op, row, col, value, eval_tb,
//   eval_d. Ops 0..2 write one breathing-axis point, diameter-axis point or
//   table entry and complete in the cycle of the transaction; no result.
//   Op 3 evaluates and produces one result transaction on the output channel
//   (out_valid/out_ready): factor, tb_cell, d_cell, outside, degenerate.
//   Config channel (cfg_valid/cfg_ready) writes grid_points_used; always ready,
//   to be written only while the block is idle.
// An evaluate, once accepted, runs an axis scan over the points in use, a table
//   fetch, two weight divisions (restoring, one quotient bit a cycle), three
//   lerps (a multiply and an add-and-saturate step each) and an output step;
//   a zero-width cell skips the divisions and lerps. in_ready rises together
//   with out_valid, so evaluates do not overlap; in_ready is high whenever the
//   sequencer is idle, also while a finished result waits in the output register.
// Reset clears the sequencer and the output valid and sets grid_points_used to
// 16; memory contents are undefined until written. A stalled result holds in
// the output register; a following evaluate waits at its last step.
module bilinear_table_interpolator_core
	import bti_pkg::*;
#(
	parameter int GRID_POINTS = 16,
	parameter int FRAC_BITS   = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [6:0]         cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         op,
	input  logic [5:0]         row,
	input  logic [5:0]         col,
	input  logic signed [31:0] value,
	input  logic signed [31:0] eval_tb,
	input  logic signed [31:0] eval_d,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] factor,
	output logic [5:0]         tb_cell,
	output logic [5:0]         d_cell,
	output logic               outside,
	output logic               degenerate
);

	localparam int AW = (GRID_POINTS > 2) ? $clog2(GRID_POINTS) : 1;
	localparam int KW = $clog2(GRID_POINTS + 1);
	localparam int TD = GRID_POINTS * GRID_POINTS;
	localparam int TW = $clog2(TD);
	localparam int NW = 33 + FRAC_BITS;           // dividend magnitude width

	// ---------------- configuration ----------------
	logic [6:0] gpu_q;
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gpu_q <= 7'd16;
		end else if (cfg_valid) begin
			gpu_q <= cfg_data;
		end
	end

	logic [KW-1:0] n_eff;
	always_comb begin
		if (gpu_q < 7'd2) begin
			n_eff = KW'(2);
		end else if (int'(gpu_q) > GRID_POINTS) begin
			n_eff = KW'(GRID_POINTS);
		end else begin
			n_eff = KW'(gpu_q);
		end
	end

	// ---------------- control ----------------
	state_t state_q;
	logic   in_acc;
	assign in_ready = (state_q == ST_IDLE);
	assign in_acc   = in_valid && in_ready;

	// ---------------- memories ----------------
	logic signed [31:0] tb_mem [GRID_POINTS];
	logic signed [31:0] d_mem  [GRID_POINTS];
	logic signed [31:0] t_mem  [TD];
	logic signed [31:0] tb_rd, d_rd, t_rd;
	logic [KW-1:0]      k_q;
	logic [TW-1:0]      t_ra;
	logic               tb_we, d_we, t_we;
	logic [TW-1:0]      t_wa;

	assign tb_we = in_acc && (op == OP_WR_TB) && (int'(col) < GRID_POINTS);
	assign d_we  = in_acc && (op == OP_WR_D) && (int'(row) < GRID_POINTS);
	assign t_we  = in_acc && (op == OP_WR_TBL) && (int'(row) < GRID_POINTS)
		&& (int'(col) < GRID_POINTS);
	assign t_wa  = TW'(int'(row) * GRID_POINTS + int'(col));

	always_ff @(posedge clk) begin
		if (tb_we) begin
			tb_mem[col[AW-1:0]] <= value;
		end
		tb_rd <= tb_mem[k_q[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (d_we) begin
			d_mem[row[AW-1:0]] <= value;
		end
		d_rd <= d_mem[k_q[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (t_we) begin
			t_mem[t_wa] <= value;
		end
		t_rd <= t_mem[t_ra];
	end

	// ---------------- evaluate datapath registers ----------------
	logic signed [31:0] x_q, y_q;
	logic               rvld_s1;
	logic [KW-1:0]      ridx_s1;
	logic signed [31:0] tb_prev_q, d_prev_q;
	logic [AW-1:0]      jj_q, ii_q;
	logic               ftb_q, fd_q;
	logic signed [31:0] tb_lo_q, tb_hi_q, d_lo_q, d_hi_q;
	logic [2:0]         tc_q;
	logic               tvld_s1;
	logic [1:0]         tidx_s1;
	logic signed [31:0] f00_q, f01_q, f10_q, f11_q;
	logic               degen_q;
	logic               dsel_q;                 // 0 breathing weight, 1 diameter weight
	logic [4:0]         dcnt_q;
	logic [33:0]        rem_q;
	logic [32:0]        den_q;
	logic [QBITS-1:0]   nlo_q;
	logic [QBITS-1:0]   quo_q;
	logic               qneg_q, qovf_q;
	logic signed [31:0] wtb_q, wd_q;
	logic [1:0]         lsel_q;
	logic               lph_q;                  // 0 multiply, 1 add and saturate
	logic signed [63:0] prod_q;
	logic signed [31:0] lo_r_q, hi_r_q, res_q;

	// search compare on the returning axis read
	logic tb_hit, d_hit, srch_done;
	assign tb_hit = (tb_prev_q <= x_q) && (x_q < tb_rd);
	assign d_hit  = (d_prev_q <= y_q) && (y_q < d_rd);
	assign srch_done = rvld_s1 && (ridx_s1 == n_eff - KW'(1));

	// table address: corners of the chosen cell
	logic [TW-1:0] t_base;
	assign t_base = TW'(int'(ii_q) * GRID_POINTS + int'(jj_q));
	always_comb begin
		unique case (tc_q[1:0])
			2'd0:    t_ra = t_base;
			2'd1:    t_ra = t_base + TW'(1);
			2'd2:    t_ra = t_base + TW'(GRID_POINTS);
			default: t_ra = t_base + TW'(GRID_POINTS + 1);
		endcase
	end

	// cell widths
	logic signed [32:0] wid_tb, wid_d;
	assign wid_tb = 33'(tb_hi_q) - 33'(tb_lo_q);
	assign wid_d  = 33'(d_hi_q) - 33'(d_lo_q);

	// divider setup
	logic signed [32:0] dnum, dden;
	logic [32:0]        num_mag33, den_mag;
	logic [NW-1:0]      num_mag;
	always_comb begin
		dnum = dsel_q ? (33'(y_q) - 33'(d_lo_q)) : (33'(x_q) - 33'(tb_lo_q));
		dden = dsel_q ? wid_d : wid_tb;
		num_mag33 = dnum[32] ? 33'(-dnum) : 33'(dnum);
		den_mag   = dden[32] ? 33'(-dden) : 33'(dden);
		num_mag   = NW'(num_mag33) << FRAC_BITS;
	end

	// divider step
	logic [33:0] dtrial;
	logic        dge;
	assign dtrial = {rem_q[32:0], nlo_q[QBITS-1]};
	assign dge    = dtrial >= {1'b0, den_q};

	// weight from finished quotient
	logic [30:0]        wmag;
	logic signed [31:0] wsig;
	logic [QBITS-1:0]   qfin;
	assign qfin = {quo_q[QBITS-2:0], dge};
	always_comb begin
		if (qovf_q || (qfin > W_LIMIT)) begin
			wmag = W_LIMIT;
		end else begin
			wmag = qfin;
		end
		wsig = qneg_q ? -$signed({1'b0, wmag}) : $signed({1'b0, wmag});
	end

	// lerp operands
	logic signed [31:0] la, lb, lw;
	logic signed [32:0] ldiff;
	logic signed [64:0] lsum;
	logic signed [31:0] lsat;
	always_comb begin
		unique case (lsel_q)
			2'd0: begin
				la = f00_q; lb = f01_q; lw = wtb_q;
			end
			2'd1: begin
				la = f10_q; lb = f11_q; lw = wtb_q;
			end
			default: begin
				la = lo_r_q; lb = hi_r_q; lw = wd_q;
			end
		endcase
		ldiff = 33'(lb) - 33'(la);
		lsum  = 65'(la) + 65'(prod_q >>> FRAC_BITS);
		if (lsum > 65'sd2147483647) begin
			lsat = 32'sh7FFF_FFFF;
		end else if (lsum < -65'sd2147483648) begin
			lsat = 32'sh8000_0000;
		end else begin
			lsat = 32'(lsum);
		end
	end

	logic out_free;
	assign out_free = !out_valid || out_ready;

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= '0;
			rvld_s1 <= 1'b0;
			ridx_s1 <= '0;
			tc_q    <= '0;
			tvld_s1 <= 1'b0;
			tidx_s1 <= '0;
			dcnt_q  <= '0;
			dsel_q  <= 1'b0;
			lsel_q  <= '0;
			lph_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					k_q     <= '0;
					rvld_s1 <= 1'b0;
					if (in_acc && (op == OP_EVAL)) begin
						state_q <= ST_SRCH;
					end
				end
				ST_SRCH: begin
					rvld_s1 <= (k_q < n_eff);
					ridx_s1 <= k_q;
					if (k_q < n_eff) begin
						k_q <= k_q + KW'(1);
					end
					if (srch_done) begin
						state_q <= ST_TRD;
						rvld_s1 <= 1'b0;
						tc_q    <= '0;
						tvld_s1 <= 1'b0;
					end
				end
				ST_TRD: begin
					tvld_s1 <= !tc_q[2];
					tidx_s1 <= tc_q[1:0];
					if (!tc_q[2]) begin
						tc_q <= tc_q + 3'd1;
					end
					if (tvld_s1 && (tidx_s1 == 2'd3)) begin
						dsel_q <= 1'b0;
						if (degen_q) begin
							state_q <= ST_OUT;
						end else begin
							state_q <= ST_DIVI;
						end
					end
				end
				ST_DIVI: begin
					dcnt_q  <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					dcnt_q <= dcnt_q + 5'd1;
					if (dcnt_q == 5'(QBITS - 1)) begin
						if (dsel_q) begin
							state_q <= ST_LRP;
							lsel_q  <= '0;
							lph_q   <= 1'b0;
						end else begin
							dsel_q  <= 1'b1;
							state_q <= ST_DIVI;
						end
					end
				end
				ST_LRP: begin
					lph_q <= !lph_q;
					if (lph_q) begin
						lsel_q <= lsel_q + 2'd1;
						if (lsel_q == 2'd2) begin
							state_q <= ST_OUT;
						end
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// ---------------- datapath (no reset) ----------------
	always_ff @(posedge clk) begin
		if (in_acc) begin
			x_q <= eval_tb;
			y_q <= eval_d;
		end
		if ((state_q == ST_SRCH) && rvld_s1) begin
			tb_prev_q <= tb_rd;
			d_prev_q  <= d_rd;
			if (ridx_s1 == KW'(1)) begin
				// cell 0 doubles as the fallback for a coordinate in no cell
				jj_q    <= '0;
				tb_lo_q <= tb_prev_q;
				tb_hi_q <= tb_rd;
				ftb_q   <= tb_hit;
				ii_q    <= '0;
				d_lo_q  <= d_prev_q;
				d_hi_q  <= d_rd;
				fd_q    <= d_hit;
			end else if (ridx_s1 > KW'(1)) begin
				if (tb_hit) begin
					jj_q    <= AW'(ridx_s1 - KW'(1));
					tb_lo_q <= tb_prev_q;
					tb_hi_q <= tb_rd;
					ftb_q   <= 1'b1;
				end
				if (d_hit) begin
					ii_q   <= AW'(ridx_s1 - KW'(1));
					d_lo_q <= d_prev_q;
					d_hi_q <= d_rd;
					fd_q   <= 1'b1;
				end
			end
		end
		if (state_q == ST_TRD) begin
			degen_q <= (wid_tb == '0) || (wid_d == '0);
			if (tvld_s1) begin
				unique case (tidx_s1)
					2'd0:    f00_q <= t_rd;
					2'd1:    f01_q <= t_rd;
					2'd2:    f10_q <= t_rd;
					default: f11_q <= t_rd;
				endcase
			end
		end
		if (state_q == ST_DIVI) begin
			den_q  <= den_mag;
			rem_q  <= 34'(num_mag >> QBITS);
			nlo_q  <= num_mag[QBITS-1:0];
			qovf_q <= (num_mag >> QBITS) >= NW'(den_mag);
			qneg_q <= dnum[32] ^ dden[32];
			quo_q  <= '0;
		end
		if (state_q == ST_DIV) begin
			rem_q <= dge ? (dtrial - {1'b0, den_q}) : dtrial;
			nlo_q <= {nlo_q[QBITS-2:0], 1'b0};
			quo_q <= qfin;
			if (dcnt_q == 5'(QBITS - 1)) begin
				if (dsel_q) begin
					wd_q <= wsig;
				end else begin
					wtb_q <= wsig;
				end
			end
		end
		if (state_q == ST_LRP) begin
			if (!lph_q) begin
				prod_q <= 64'(ldiff * lw);
			end else begin
				unique case (lsel_q)
					2'd0:    lo_r_q <= lsat;
					2'd1:    hi_r_q <= lsat;
					default: res_q  <= lsat;
				endcase
			end
		end
	end

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if ((state_q == ST_OUT) && out_free) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_OUT) && out_free) begin
			factor     <= degen_q ? f00_q : res_q;
			tb_cell    <= 6'(jj_q);
			d_cell     <= 6'(ii_q);
			outside    <= !(ftb_q && fd_q);
			degenerate <= degen_q;
		end
	end

`ifndef SYNTH
	a_eval_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && (op == OP_EVAL)) |=> !in_ready)
		else $error("evaluate did not block the input");
	a_res_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_OUT))
		else $error("result raised outside the output step");
	a_div_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (dcnt_q <= 5'(QBITS - 1)))
		else $error("divider count overran");
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SRCH) |-> (k_q <= n_eff))
		else $error("axis scan ran past the points in use");
`endif

endmodule
